FILE: rtl/scrolling_led_column_marquee_assert.svh
// Assertion macros used by the marquee top level.
`ifndef SCROLLING_LED_COLUMN_MARQUEE_ASSERT_SVH
`define SCROLLING_LED_COLUMN_MARQUEE_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define SLCM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("marquee check failed");
// Next-cycle implication, checked out of reset.
`define SLCM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("marquee check failed");
`else
`define SLCM_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SLCM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/slcm_pkg.sv
// Shared types, constants and glyph table of the LED column marquee.
`timescale 1ns / 1ps
package slcm_pkg;

	localparam int COLUMN_COUNT_DEF = 64;
	localparam int DELAY_BASE_DEF   = 1400;
	localparam int DELAY_STEP_DEF   = 4;

	localparam int BYTE_W      = 8;
	localparam int SPEED_W     = 8;
	localparam int READ_COL_W  = 6;
	localparam int MODE_W      = 2;
	localparam int CNT_W       = 11;
	localparam int GLYPH_DEPTH = 64;

	typedef enum logic [MODE_W-1:0] {
		MODE_INIT  = 2'd0,
		MODE_HORIZ = 2'd1,
		MODE_VERT  = 2'd2
	} mode_t;

	typedef struct packed {
		logic                  btn_initialize;
		logic                  btn_horizontal;
		logic                  btn_vertical;
		logic [SPEED_W-1:0]    speed;
		logic [READ_COL_W-1:0] read_column;
	} tick_t;

	typedef struct packed {
		logic [BYTE_W-1:0] column_value;
		logic              step_fired;
		logic [MODE_W-1:0] current_mode;
	} result_t;

	// Store update request from the timing logic.
	typedef struct packed {
		logic  apply;
		mode_t mode;
	} store_ctrl_t;

	localparam logic [BYTE_W-1:0] GLYPH_ROM [GLYPH_DEPTH] = '{
		8'd0, 8'd66,  8'd102, 8'd24, 8'd24, 8'd102, 8'd66,  8'd0,
		8'd0, 8'd60,  8'd70,  8'd66, 8'd82, 8'd82,  8'd50,  8'd0,
		8'd0, 8'd126, 8'd96,  8'd64, 8'd64, 8'd96,  8'd126, 8'd0,
		8'd0, 8'd126, 8'd126, 8'd64, 8'd64, 8'd64,  8'd96,  8'd0,
		8'd0, 8'd96,  8'd56,  8'd38, 8'd38, 8'd56,  8'd96,  8'd0,
		8'd0, 8'd126, 8'd12,  8'd24, 8'd48, 8'd96,  8'd126, 8'd0,
		8'd0, 8'd60,  8'd102, 8'd66, 8'd66, 8'd102, 8'd60,  8'd0,
		8'd0, 8'd60,  8'd102, 8'd66, 8'd66, 8'd102, 8'd60,  8'd0
	};

endpackage

FILE: rtl/slcm_chan_if.sv
// Valid/ready channel carrying one payload beat.
`timescale 1ns / 1ps
interface slcm_chan_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/scrolling_led_column_marquee.sv
// Top level of the scrolling LED column marquee.
// A tick beat goes from the input register to the result register. Throughput: one
// tick per cycle unless the result side stalls; the counter, mode latch and column
// registers update in the cycle a tick moves from the input to the result register.
// Reset: columns reload the glyph pattern, mode returns to initialize, counter to 0.
`timescale 1ns / 1ps
`include "scrolling_led_column_marquee_assert.svh"
module scrolling_led_column_marquee
	import slcm_pkg::*;
#(
	parameter int COLUMN_COUNT = COLUMN_COUNT_DEF,
	parameter int DELAY_BASE   = DELAY_BASE_DEF,
	parameter int DELAY_STEP   = DELAY_STEP_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	slcm_chan_if.sink   tick,
	slcm_chan_if.source result
);

	localparam int SUM_W = CNT_W + 2;

	tick_t       tick_s1;
	logic        valid_s1;
	result_t     result_q;
	logic        result_valid_q;
	mode_t       mode_q;
	mode_t       mode_d;
	logic [CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0] step_prod;
	logic [SUM_W-1:0] cnt_sum;
	logic        fire;
	logic        advance;
	store_ctrl_t store_ctrl;
	logic [BYTE_W-1:0] column_value;

	assign advance    = valid_s1 && (!result_valid_q || result.ready);
	assign tick.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			tick_s1 <= tick.data;
		end
	end

	// Button priority: horizontal, vertical, initialize; hold if none pressed.
	always_comb begin
		mode_d = mode_q;
		if (tick_s1.btn_horizontal) begin
			mode_d = MODE_HORIZ;
		end else if (tick_s1.btn_vertical) begin
			mode_d = MODE_VERT;
		end else if (tick_s1.btn_initialize) begin
			mode_d = MODE_INIT;
		end
	end

	// Fire when count + 1 >= base - step * speed, floored at a period of one.
	assign step_prod = SUM_W'(DELAY_STEP) * SUM_W'(tick_s1.speed);
	assign cnt_sum   = SUM_W'(cnt_q) + SUM_W'(1) + step_prod;
	assign fire      = (step_prod >= SUM_W'(DELAY_BASE)) || (cnt_sum >= SUM_W'(DELAY_BASE));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_INIT;
			cnt_q  <= '0;
		end else if (advance) begin
			mode_q <= mode_d;
			cnt_q  <= fire ? '0 : cnt_q + CNT_W'(1);
		end
	end

	assign store_ctrl.apply = advance && fire;
	assign store_ctrl.mode  = mode_d;

	slcm_store #(
		.COLUMN_COUNT(COLUMN_COUNT)
	) u_store (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (store_ctrl),
		.read_column  (tick_s1.read_column),
		.column_value (column_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (result.ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q.column_value <= column_value;
			result_q.step_fired   <= fire;
			result_q.current_mode <= mode_d;
		end
	end

	assign result.valid = result_valid_q;
	assign result.data  = result_q;

	`SLCM_ASSERT_NOW(a_cnt_below_base, clk, arst_n, 1'b1, cnt_q < CNT_W'(DELAY_BASE))
	`SLCM_ASSERT_NEXT(a_cnt_clear_on_fire, clk, arst_n, advance && fire, cnt_q == '0)
	`SLCM_ASSERT_NOW(a_stall_only_when_full, clk, arst_n, !tick.ready, valid_s1 && result_valid_q)

endmodule

FILE: rtl/slcm_store.sv
// Column store: glyph reload, column rotation, bit rotation and read-back mux.
`timescale 1ns / 1ps
module slcm_store
	import slcm_pkg::*;
#(
	parameter int COLUMN_COUNT = COLUMN_COUNT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  store_ctrl_t           ctrl,
	input  logic [READ_COL_W-1:0] read_column,
	output logic [BYTE_W-1:0]     column_value
);

	localparam int COL_IDX_W = $clog2(COLUMN_COUNT);
	localparam int RD_W      = ((COL_IDX_W > READ_COL_W) ? COL_IDX_W : READ_COL_W) + 1;

	logic [BYTE_W-1:0]    store_q [COLUMN_COUNT];
	logic [BYTE_W-1:0]    store_d [COLUMN_COUNT];
	logic [RD_W-1:0]      rd_ext;
	logic [COL_IDX_W-1:0] rd_idx;
	logic                 rd_in_range;

	for (genvar i = 0; i < COLUMN_COUNT; i++) begin : g_col
		localparam int NXT = (i + 1) % COLUMN_COUNT;
		localparam int GLY = i % GLYPH_DEPTH;

		always_comb begin
			store_d[i] = store_q[i];
			if (ctrl.apply) begin
				unique case (ctrl.mode)
					MODE_HORIZ: store_d[i] = store_q[NXT];
					MODE_VERT:  store_d[i] = {store_q[i][BYTE_W-2:0], store_q[i][BYTE_W-1]};
					MODE_INIT:  store_d[i] = GLYPH_ROM[GLY];
					default:    store_d[i] = GLYPH_ROM[GLY];
				endcase
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				store_q[i] <= GLYPH_ROM[GLY];
			end else begin
				store_q[i] <= store_d[i];
			end
		end
	end

	// Report the column as it stands after this tick's update.
	assign rd_ext      = RD_W'(read_column);
	assign rd_in_range = rd_ext < RD_W'(COLUMN_COUNT);
	assign rd_idx      = rd_ext[COL_IDX_W-1:0];
	assign column_value = rd_in_range ? store_d[rd_idx] : '0;

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the scrolling LED column marquee.
`timescale 1ns / 1ps
module tb
	import slcm_pkg::*;
();

	localparam int COLUMNS     = COLUMN_COUNT_DEF;
	localparam int DELAY_BASE  = DELAY_BASE_DEF;
	localparam int DELAY_STEP  = DELAY_STEP_DEF;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int MIN_TICKS   = 900;

	// Tracks the column store, mode and tick count, and holds the result beats still owed.
	class marquee_tracker;
		logic [BYTE_W-1:0] columns [COLUMNS];
		mode_t             mode;
		logic [CNT_W-1:0]  ticks_since_step;
		result_t           pending_results [$];
		int                errors;
		int                steps;
		int                steps_in_mode [3];
		int                results_seen;

		function new();
			reload_glyphs();
			mode = MODE_INIT;
			ticks_since_step = '0;
			errors = 0;
			steps = 0;
			results_seen = 0;
			foreach (steps_in_mode[m]) steps_in_mode[m] = 0;
		endfunction

		function void reload_glyphs();
			for (int i = 0; i < COLUMNS; i++) columns[i] = GLYPH_ROM[i % GLYPH_DEPTH];
		endfunction

		function void report(string msg);
			errors++;
			if (errors <= 10) $display("[%0t] %s", $realtime, msg);
		endfunction

		function void note_tick(tick_t t);
			int                period;
			logic [BYTE_W-1:0] first;
			result_t           r;
			if (t.btn_horizontal) mode = MODE_HORIZ;
			else if (t.btn_vertical) mode = MODE_VERT;
			else if (t.btn_initialize) mode = MODE_INIT;
			period = DELAY_BASE - DELAY_STEP * int'(t.speed);
			if (period < 1) period = 1;
			r.step_fired = 1'b0;
			if (int'(ticks_since_step) + 1 >= period) begin
				r.step_fired = 1'b1;
				ticks_since_step = '0;
				steps++;
				steps_in_mode[mode]++;
				case (mode)
					MODE_HORIZ: begin
						first = columns[0];
						for (int i = 0; i < COLUMNS - 1; i++) columns[i] = columns[i + 1];
						columns[COLUMNS - 1] = first;
					end
					MODE_VERT: begin
						foreach (columns[i])
							columns[i] = {columns[i][BYTE_W-2:0], columns[i][BYTE_W-1]};
					end
					default: begin
						reload_glyphs();
					end
				endcase
			end else begin
				ticks_since_step = ticks_since_step + 1'b1;
			end
			r.column_value = (int'(t.read_column) < COLUMNS) ? columns[t.read_column] : '0;
			r.current_mode = mode;
			pending_results.push_back(r);
		endfunction

		function void check_result(result_t got);
			result_t want;
			results_seen++;
			if (pending_results.size() == 0) begin
				report($sformatf("unexpected result beat: column %0d fired %0d mode %0d",
					got.column_value, got.step_fired, got.current_mode));
				return;
			end
			want = pending_results.pop_front();
			if (got.column_value !== want.column_value || got.step_fired !== want.step_fired
					|| got.current_mode !== want.current_mode) begin
				report($sformatf("result %0d: column %0d/%0d fired %0d/%0d mode %0d/%0d (exp/got)",
					results_seen, want.column_value, got.column_value, want.step_fired,
					got.step_fired, want.current_mode, got.current_mode));
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   tx_idle = 29;
	int   rx_idle = 49;
	int   cycles  = 0;

	marquee_tracker tracker = new();

	slcm_chan_if #(.payload_t(tick_t))   tick_if ();
	slcm_chan_if #(.payload_t(result_t)) result_if ();

	scrolling_led_column_marquee u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick_if.sink),
		.result (result_if.source)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				tracker.pending_results.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(negedge clk) begin
		result_if.ready = ($urandom_range(99) >= rx_idle);
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && tick_if.valid === 1'b1 && tick_if.ready === 1'b1)
			tracker.note_tick(tick_if.data);
		if (arst_n === 1'b1 && result_if.valid === 1'b1 && result_if.ready === 1'b1)
			tracker.check_result(result_if.data);
	end

	function automatic tick_t make_tick(logic init, logic horiz, logic vert,
			logic [SPEED_W-1:0] speed, logic [READ_COL_W-1:0] col);
		tick_t t;
		t.btn_initialize = init;
		t.btn_horizontal = horiz;
		t.btn_vertical   = vert;
		t.speed          = speed;
		t.read_column    = col;
		return t;
	endfunction

	function automatic logic [READ_COL_W-1:0] any_column();
		return READ_COL_W'($urandom_range(COLUMNS - 1));
	endfunction

	function automatic logic any_bit();
		return 1'($urandom_range(1));
	endfunction

	// Called just after a falling edge; returns just after the falling edge that follows
	// the beat.
	task automatic send_tick(input tick_t t);
		while ($urandom_range(99) < tx_idle) begin
			tick_if.valid = 1'b0;
			@(negedge clk);
		end
		tick_if.valid = 1'b1;
		tick_if.data  = t;
		do @(posedge clk); while (tick_if.ready !== 1'b1);
		@(negedge clk);
	endtask

	// Hold the sender until every owed result beat has come back.
	task automatic wait_drain();
		tick_if.valid = 1'b0;
		do @(negedge clk); while (tracker.pending_results.size() != 0);
	endtask

	// Spread the idling over the run: receiver-heavy, then sender-heavy, then none.
	task automatic pick_idling(input int done);
		if (done < MIN_TICKS / 3) begin
			tx_idle = 29;
			rx_idle = 49;
		end else if (done < 2 * MIN_TICKS / 3) begin
			tx_idle = 49;
			rx_idle = 29;
		end else begin
			tx_idle = 0;
			rx_idle = 0;
		end
	endtask

	initial begin
		int                 sent;
		int                 kind;
		int                 run_len;
		int                 start_steps;
		mode_t              target;
		logic [SPEED_W-1:0] run_speed;
		tick_t              t;

		sent = 0;
		arst_n = 1'b0;
		tick_if.valid = 1'b0;
		tick_if.data = '0;
		result_if.ready = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: reset pattern, field extremes, each button alone and in every mix.
		send_tick(make_tick(1'b0, 1'b0, 1'b0, 8'd0, 6'd0));
		send_tick(make_tick(1'b0, 1'b0, 1'b0, 8'd255, 6'd63));
		send_tick(make_tick(1'b0, 1'b1, 1'b0, 8'd1, 6'd1));
		send_tick(make_tick(1'b0, 1'b0, 1'b0, 8'd254, 6'd2));
		send_tick(make_tick(1'b0, 1'b0, 1'b1, 8'd128, 6'd62));
		send_tick(make_tick(1'b1, 1'b0, 1'b0, 8'd127, 6'd9));
		send_tick(make_tick(1'b0, 1'b1, 1'b1, 8'hAA, 6'h2A));
		send_tick(make_tick(1'b1, 1'b0, 1'b1, 8'h55, 6'h15));
		send_tick(make_tick(1'b1, 1'b1, 1'b0, 8'd0, 6'd10));
		send_tick(make_tick(1'b1, 1'b1, 1'b1, 8'd255, 6'd17));
		send_tick(make_tick(1'b0, 1'b0, 1'b0, 8'd64, 6'd32));
		send_tick(make_tick(1'b1, 1'b0, 1'b0, 8'd32, 6'd31));
		for (int c = 0; c < 8; c++)
			send_tick(make_tick(1'b0, 1'b0, 1'b0, 8'd200, READ_COL_W'(c * 9)));
		wait_drain();

		while (sent < MIN_TICKS) begin
			pick_idling(sent);
			kind = $urandom_range(99);
			if (kind < 65) begin
				// Steady run: pick a mode, hold the speed, tick until the store steps or the run cap is hit.
				target = mode_t'($urandom_range(2));
				run_speed = ($urandom_range(9) < 8) ? SPEED_W'($urandom_range(255, 224))
					: SPEED_W'($urandom_range(255));
				case (target)
					MODE_HORIZ: t = make_tick(any_bit(), 1'b1, any_bit(),
						run_speed, any_column());
					MODE_VERT: t = make_tick(any_bit(), 1'b0, 1'b1, run_speed,
						any_column());
					default: t = make_tick(1'b1, 1'b0, 1'b0, run_speed, any_column());
				endcase
				start_steps = tracker.steps;
				send_tick(t);
				sent++;
				run_len = 0;
				while (tracker.steps == start_steps && run_len < 1500 && sent < MIN_TICKS)
						begin
					if ($urandom_range(99) < 3)
						t = make_tick(any_bit(), any_bit(), any_bit(),
							run_speed, any_column());
					else
						t = make_tick(1'b0, 1'b0, 1'b0, run_speed, any_column());
					send_tick(t);
					sent++;
					run_len++;
				end
			end else if (kind < 80) begin
				// Build up the count slowly, then raise the speed so the next tick may step.
				wait_drain();
				run_len = $urandom_range(520, 380);
				if (run_len > MIN_TICKS - sent) run_len = MIN_TICKS - sent;
				repeat (run_len) begin
					send_tick(make_tick(1'b0, 1'b0, 1'b0, 8'd0, any_column()));
					sent++;
				end
				send_tick(make_tick(1'b0, 1'b0, 1'b0, SPEED_W'($urandom_range(255, 200)),
					any_column()));
				sent++;
			end else begin
				run_len = $urandom_range(30, 10);
				repeat (run_len) begin
					send_tick(make_tick(any_bit(), any_bit(), any_bit(),
						SPEED_W'($urandom_range(255)), any_column()));
					sent++;
				end
			end
		end

		wait_drain();
		repeat (8) @(negedge clk);
		if (tracker.pending_results.size() != 0)
			tracker.report($sformatf("%0d result beats never arrived",
				tracker.pending_results.size()));

		$display("Ran %0d random ticks, %0d result beats checked, %0d mismatches.",
			sent, tracker.results_seen, tracker.errors);
		$display("Store steps: %0d initialize, %0d horizontal, %0d vertical.",
			tracker.steps_in_mode[MODE_INIT], tracker.steps_in_mode[MODE_HORIZ],
			tracker.steps_in_mode[MODE_VERT]);
		if (tracker.errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
